>>> rtl/sidta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII package
// Shared constants, microcode word layout, control and status structs and
// the microcode program of the converter.
// ----------------------------------------------------------------------------
package sidta_pkg;

    localparam int ValueW    = 32;
    localparam int NumDigits = 10;
    localparam int DigitIdxW = $clog2(NumDigits);
    localparam int NumShift  = ValueW;
    localparam int CntW      = $clog2(NumShift);
    localparam int StepW     = 3;
    localparam int CharW     = 8;

    localparam logic [CharW-1:0]     CharMinus = 8'h2D;
    localparam logic [CharW-1:0]     CharZero  = 8'h30;
    localparam logic [DigitIdxW-1:0] TopDigit  = DigitIdxW'(NumDigits - 1);
    localparam logic [CntW-1:0]      ShiftLast = CntW'(NumShift - 1);

    typedef logic [StepW-1:0] t_step;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SHIFT,
        OP_PTR_INIT,
        OP_SKIP,
        OP_SIGN,
        OP_DIGIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_VALID,
        COND_CNT_NZ,
        COND_LEAD_ZERO,
        COND_PTR_NZ
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic hold;
    } t_ctrl;

    typedef struct packed {
        logic neg;
        logic out_busy;
        logic cnt_nz;
        logic lead_zero;
        logic ptr_nz;
    } t_status;

    localparam t_step StepLoad    = 3'd0;
    localparam t_step StepShift   = 3'd1;
    localparam t_step StepPtrInit = 3'd2;
    localparam t_step StepSkip    = 3'd3;
    localparam t_step StepSign    = 3'd4;
    localparam t_step StepDigit   = 3'd5;
    localparam t_step StepDone    = 3'd6;

    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        case (step)
            StepLoad:    w = '{op: OP_LOAD,     cond: COND_NO_VALID,  target: StepLoad};
            StepShift:   w = '{op: OP_SHIFT,    cond: COND_CNT_NZ,    target: StepShift};
            StepPtrInit: w = '{op: OP_PTR_INIT, cond: COND_NEXT,      target: StepLoad};
            StepSkip:    w = '{op: OP_SKIP,     cond: COND_LEAD_ZERO, target: StepSkip};
            StepSign:    w = '{op: OP_SIGN,     cond: COND_NEXT,      target: StepLoad};
            StepDigit:   w = '{op: OP_DIGIT,    cond: COND_PTR_NZ,    target: StepDigit};
            StepDone:    w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: StepLoad};
            default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: StepLoad};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

>>> rtl/sidta_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the microcode table with conditional jumps and a hold
// while the output register is still occupied.
// ----------------------------------------------------------------------------
module sidta_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire sidta_pkg::t_status i_status,
    output sidta_pkg::t_ctrl        o_ctrl
);

    sidta_pkg::t_step  r_step;
    sidta_pkg::t_step  n_step;
    sidta_pkg::t_uword w_uword;
    logic              w_take;
    logic              w_hold;

    assign w_uword = sidta_pkg::ucode_rom(r_step);

    always_comb begin
        case (w_uword.cond)
            sidta_pkg::COND_NEXT:      w_take = 1'b0;
            sidta_pkg::COND_ALWAYS:    w_take = 1'b1;
            sidta_pkg::COND_NO_VALID:  w_take = !i_in_valid;
            sidta_pkg::COND_CNT_NZ:    w_take = i_status.cnt_nz;
            sidta_pkg::COND_LEAD_ZERO: w_take = i_status.lead_zero;
            sidta_pkg::COND_PTR_NZ:    w_take = i_status.ptr_nz;
            default:                   w_take = 1'b0;
        endcase
    end

    always_comb begin
        w_hold = i_status.out_busy &&
                 ((w_uword.op == sidta_pkg::OP_DIGIT) ||
                  ((w_uword.op == sidta_pkg::OP_SIGN) && i_status.neg));
    end

    always_comb begin
        if (w_hold) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = w_uword.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sidta_pkg::StepLoad;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = '{op: w_uword.op, hold: w_hold};

endmodule
`default_nettype wire

>>> rtl/sidta_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Conversion datapath
// Magnitude and sign capture, shift-and-add-3 BCD register, digit pointer
// and the registered character output.
// ----------------------------------------------------------------------------
module sidta_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire sidta_pkg::t_ctrl                   i_ctrl,
    input  wire logic                               i_in_valid,
    input  wire logic signed [sidta_pkg::ValueW-1:0] i_value,
    input  wire logic                               i_out_ready,
    output sidta_pkg::t_status                      o_status,
    output logic                                    o_out_valid,
    output logic [sidta_pkg::CharW-1:0]             o_text_char,
    output logic                                    o_last
);

    logic [sidta_pkg::ValueW-1:0]    r_mag;
    logic [sidta_pkg::ValueW-1:0]    n_mag;
    logic                            r_neg;
    logic                            n_neg;
    logic [3:0]                      r_bcd [sidta_pkg::NumDigits];
    logic [3:0]                      n_bcd [sidta_pkg::NumDigits];
    logic [3:0]                      w_adj [sidta_pkg::NumDigits];
    logic [sidta_pkg::CntW-1:0]      r_cnt;
    logic [sidta_pkg::CntW-1:0]      n_cnt;
    logic [sidta_pkg::DigitIdxW-1:0] r_ptr;
    logic [sidta_pkg::DigitIdxW-1:0] n_ptr;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic [sidta_pkg::CharW-1:0]     r_out_char;
    logic [sidta_pkg::CharW-1:0]     n_out_char;
    logic                            r_out_last;
    logic                            n_out_last;
    logic [3:0]                      w_cur_digit;
    logic                            w_ptr_nz;
    logic                            w_load;
    logic                            w_run;

    assign w_cur_digit = r_bcd[r_ptr];
    assign w_ptr_nz    = (r_ptr != '0);
    assign w_run       = !i_ctrl.hold;
    assign w_load      = (i_ctrl.op == sidta_pkg::OP_LOAD) && i_in_valid;

    always_comb begin
        for (int i = 0; i < sidta_pkg::NumDigits; i++) begin
            w_adj[i] = (r_bcd[i] >= 4'd5) ? (r_bcd[i] + 4'd3) : r_bcd[i];
        end
    end

    always_comb begin
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_bcd       = r_bcd;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_out_ready;
        case (i_ctrl.op)
            sidta_pkg::OP_LOAD: begin
                if (w_load) begin
                    n_neg = i_value[sidta_pkg::ValueW-1];
                    n_mag = i_value[sidta_pkg::ValueW-1] ? (~i_value + 1'b1) : i_value;
                    n_cnt = sidta_pkg::ShiftLast;
                    for (int i = 0; i < sidta_pkg::NumDigits; i++) begin
                        n_bcd[i] = 4'd0;
                    end
                end
            end
            sidta_pkg::OP_SHIFT: begin
                n_mag = {r_mag[sidta_pkg::ValueW-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                n_bcd[0] = {w_adj[0][2:0], r_mag[sidta_pkg::ValueW-1]};
                for (int i = 1; i < sidta_pkg::NumDigits; i++) begin
                    n_bcd[i] = {w_adj[i][2:0], w_adj[i-1][3]};
                end
            end
            sidta_pkg::OP_PTR_INIT: begin
                n_ptr = sidta_pkg::TopDigit;
            end
            sidta_pkg::OP_SKIP: begin
                if (w_ptr_nz && (w_cur_digit == 4'd0)) begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            sidta_pkg::OP_SIGN: begin
                if (w_run && r_neg) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sidta_pkg::CharMinus;
                    n_out_last  = 1'b0;
                end
            end
            sidta_pkg::OP_DIGIT: begin
                if (w_run) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sidta_pkg::CharZero | {4'd0, w_cur_digit};
                    n_out_last  = !w_ptr_nz;
                    if (w_ptr_nz) begin
                        n_ptr = r_ptr - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_ptr       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_bcd      <= n_bcd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_status = '{
        neg:       r_neg,
        out_busy:  r_out_valid && !i_out_ready,
        cnt_nz:    (r_cnt != '0),
        lead_zero: w_ptr_nz && (w_cur_digit == 4'd0),
        ptr_nz:    w_ptr_nz
    };

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_char == sidta_pkg::CharMinus) ||
                        ((r_out_char >= sidta_pkg::CharZero) &&
                         (r_out_char <= (sidta_pkg::CharZero + 8'd9))))
        else $error("output character is neither a minus sign nor a digit");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_char == sidta_pkg::CharMinus)) |-> !r_out_last)
        else $error("minus sign marked as the last character");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_cnt == sidta_pkg::ShiftLast))
        else $error("shift count not initialized on input transaction");
`endif

endmodule
`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII converter
// Converts a signed 32-bit value into its decimal text, one character per
// output transaction, with the last flag on the final character.
// ----------------------------------------------------------------------------
// Each input transaction produces an optional '-' followed by the decimal
// digits from most significant to least, without leading zeros; zero gives a
// single '0', and the most negative value gives "-2147483648". The block works
// on one value at a time: it does not accept the next value until the
// microcode program has run through all steps for the current one, and the
// sign step of a negative value or a digit step waits while the pending
// character has not been taken. The program has one load step, 32
// shift-and-add-3 steps of the BCD register, eleven steps for the ten digit
// positions (one per suppressed leading zero, one that finds the leading
// digit and one per emitted digit), and single steps for pointer setup, sign
// and completion.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [sidta_pkg::ValueW-1:0] i_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [sidta_pkg::CharW-1:0]              o_text_char,
    output logic                                     o_last
);

    sidta_pkg::t_ctrl   w_ctrl;
    sidta_pkg::t_status w_status;

    sidta_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    sidta_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_in_valid  (i_in_valid),
        .i_value     (i_value),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_text_char (o_text_char),
        .o_last      (o_last)
    );

    assign o_in_ready = (w_ctrl.op == sidta_pkg::OP_LOAD);

endmodule
`default_nettype wire
